/* hdl/dhbds_pkg.sv */
// Shared types, op codes and helper functions for the dual H-bridge
// direction sequencer. No dependencies.
package dhbds_pkg;

   localparam int unsigned CmpWidth      = 12;
   localparam int unsigned SpeedWidth    = 8;
   localparam int unsigned DeadWidth     = 8;
   localparam int unsigned EnWidth       = 4;
   localparam int unsigned ReqDataWidth  = 16;
   localparam int unsigned ReqUserWidth  = 3;
   localparam int unsigned RspDataWidth  = 56;
   localparam logic [DeadWidth-1:0] DeadTimeReset = 8'd23;
   localparam logic [EnWidth-1:0]   EnablesReset  = 4'b0110;

   typedef enum logic [1:0] {
      OP_SPEED = 2'd0,
      OP_DIR   = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   motor;
      logic                   direction;
      logic [SpeedWidth-1:0]  speed;
   } req_type;

   typedef struct packed {
      logic                   busy_res;
      logic                   accepted;
      logic [EnWidth-1:0]     enables;
      logic [CmpWidth-1:0]    right_reverse_compare;
      logic [CmpWidth-1:0]    right_forward_compare;
      logic [CmpWidth-1:0]    left_reverse_compare;
      logic [CmpWidth-1:0]    left_forward_compare;
   } rsp_type;

   // enable line of one motor and direction
   function automatic logic [EnWidth-1:0] path_bit(input logic m, input logic d);
      logic [EnWidth-1:0] bits;
      if (!m) begin
         bits = d ? 4'b1000 : 4'b0100;
      end else begin
         bits = d ? 4'b0001 : 4'b0010;
      end
      return bits;
   endfunction

   // 8-bit speed to 12-bit compare: (s << 4) + (s >> 4)
   function automatic logic [CmpWidth-1:0] scale_speed(input logic [SpeedWidth-1:0] s);
      return {s, 4'b0000} + {8'b0, s[7:4]};
   endfunction

endpackage

/* hdl/dhbds_req_reg.sv */
// Input register stage: captures one request transfer and holds it until
// the sequencer stage takes it. Depends on dhbds_pkg.
module dhbds_req_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dhbds_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dhbds_pkg::req_type out_data
);

   logic               valid_ff, valid_in;
   dhbds_pkg::req_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: load on every accepted transfer
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

/* hdl/dhbds_seq.sv */
// Sequencer state and single-pass update logic: compare values, enables,
// motor directions and the dead-time counter. Depends on dhbds_pkg.
module dhbds_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  dhbds_pkg::req_type                  req,
   input  logic [dhbds_pkg::DeadWidth-1:0]     dead_time,
   output dhbds_pkg::rsp_type                  rsp
);

   logic [dhbds_pkg::CmpWidth-1:0]  cmp_ff [4];
   logic [dhbds_pkg::CmpWidth-1:0]  cmp_in [4];
   logic [1:0]                      dir_ff, dir_in;
   logic [dhbds_pkg::EnWidth-1:0]   en_ff, en_in;
   logic                            busy_ff, busy_in;
   logic [dhbds_pkg::DeadWidth-1:0] cnt_ff, cnt_in;
   logic                            pmotor_ff, pmotor_in;
   logic                            pdir_ff, pdir_in;
   logic                            accepted;

   logic                            cur_dir;
   logic [1:0]                      cur_idx;
   logic [dhbds_pkg::DeadWidth-1:0] cnt_inc;

   assign cur_dir = dir_ff[req.motor];
   assign cur_idx = {req.motor, cur_dir};
   assign cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      cmp_in    = cmp_ff;
      dir_in    = dir_ff;
      en_in     = en_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      pmotor_in = pmotor_ff;
      pdir_in   = pdir_ff;
      accepted  = 1'b1;
      unique case (req.op)
         dhbds_pkg::OP_SPEED: begin
            cmp_in[cur_idx] = dhbds_pkg::scale_speed(req.speed);
         end
         dhbds_pkg::OP_DIR: begin
            if (busy_ff) begin
               accepted = 1'b0;
            end else begin
               cmp_in[cur_idx] = '0;
               if (cur_dir != req.direction) begin
                  en_in     = en_ff & ~dhbds_pkg::path_bit(req.motor, cur_dir);
                  busy_in   = 1'b1;
                  cnt_in    = '0;
                  pmotor_in = req.motor;
                  pdir_in   = req.direction;
               end
            end
         end
         dhbds_pkg::OP_TICK: begin
            if (busy_ff) begin
               cnt_in = cnt_inc;
               if (cnt_inc >= dead_time) begin
                  en_in             = en_ff | dhbds_pkg::path_bit(pmotor_ff, pdir_ff);
                  dir_in[pmotor_ff] = pdir_ff;
                  busy_in           = 1'b0;
                  cnt_in            = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result shows the state after this item
   always_comb begin
      rsp.left_forward_compare  = cmp_in[0];
      rsp.left_reverse_compare  = cmp_in[1];
      rsp.right_forward_compare = cmp_in[2];
      rsp.right_reverse_compare = cmp_in[3];
      rsp.enables               = en_in;
      rsp.accepted              = accepted;
      rsp.busy_res              = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff    <= '{default: '0};
         dir_ff    <= '0;
         en_ff     <= dhbds_pkg::EnablesReset;
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         pmotor_ff <= 1'b0;
         pdir_ff   <= 1'b0;
      end else if (fire) begin
         cmp_ff    <= cmp_in;
         dir_ff    <= dir_in;
         en_ff     <= en_in;
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         pmotor_ff <= pmotor_in;
         pdir_ff   <= pdir_in;
      end
   end

endmodule

/* hdl/dual_h_bridge_direction_sequencer_core.sv */
// Top level of the dual H-bridge direction sequencer: stream ports, dead-time
// register, input stage, sequencer and result register.
// Depends on dhbds_pkg, dhbds_req_reg and dhbds_seq.
//
// Usage:
//   req_* carries commands: set speed, set direction, or a time tick. Each
//   transfer on req_* produces exactly one transfer on rsp_* that reports all
//   four compare values, the enable lines, whether the command was accepted
//   and whether a direction change is waiting out its dead time.
//   csr_wr_en / csr_wr_data write the dead-time tick count; write it only
//   while no command is in flight.
// Timing:
//   A request lands in the input register when it is accepted; the update logic
//   then carries it into the result register when that register is free or
//   draining. One command per cycle is sustained while rsp_tready stays high:
//   the single-pass update between the input register and the result register
//   sets that rate.
// Reset:
//   Both motors forward, forward enables set, compare values zero, dead time
//   23 ticks, no change pending, both stages empty.
// Backpressure:
//   When rsp_tready is low the result is held; the input register still takes
//   one more request if it is empty, then req_tready drops until the result is taken.
module dual_h_bridge_direction_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dhbds_pkg::ReqDataWidth-1:0]   req_tdata,  // direction, speed[7:0], zero pad
   input  logic [dhbds_pkg::ReqUserWidth-1:0]   req_tuser,  // op[1:0], motor
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_fwd[11:0], left_rev[11:0], right_fwd[11:0], right_rev[11:0],
   // enables[3:0], accepted, busy_res, zero pad
   output logic [dhbds_pkg::RspDataWidth-1:0]   rsp_tdata,
   // dead-time register write
   input  logic                                 csr_wr_en,
   input  logic [dhbds_pkg::DeadWidth-1:0]      csr_wr_data
);

   dhbds_pkg::req_type                  req_in;
   dhbds_pkg::req_type                  stage_req;
   logic                                stage_valid;
   logic                                stage_ready;
   logic                                fire;
   dhbds_pkg::rsp_type                  seq_rsp;
   dhbds_pkg::rsp_type                  rsp_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [dhbds_pkg::DeadWidth-1:0]     dead_ff;

   // unpack the request fields
   assign req_in.op        = dhbds_pkg::op_type'(req_tuser[1:0]);
   assign req_in.motor     = req_tuser[2];
   assign req_in.direction = req_tdata[0];
   assign req_in.speed     = req_tdata[8:1];

   // hold the dead-time count; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff <= dhbds_pkg::DeadTimeReset;
      end else if (csr_wr_en) begin
         dead_ff <= csr_wr_data;
      end
   end

   dhbds_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_in),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_data  (stage_req)
   );

   // advance the staged command when the result register is free or draining
   assign stage_ready = !rsp_valid_ff || rsp_tready;
   assign fire        = stage_valid && stage_ready;

   dhbds_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (stage_req),
      .dead_time (dead_ff),
      .rsp       (seq_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_ready) begin
         rsp_valid_in = stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

   // a rejected command only ever happens while a change is pending
   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |-> rsp_ff.busy_res)
      else $error("command rejected while no direction change pending");

   // never both directions of one motor enabled
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.enables[3] && rsp_ff.enables[2]) &&
                       !(rsp_ff.enables[1] && rsp_ff.enables[0]))
      else $error("both enables of one motor set");

   // a staged command that cannot advance stays in the input register
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !stage_ready) |=> stage_valid)
      else $error("staged command lost under backpressure");

endmodule
